>>> hdl/npcd_pkg.sv
// ----------------------------------------------------------------------------
// npcd_pkg
// shared constants, types and the marker offset tables for the nand page
// codeword deinterleaver
// ----------------------------------------------------------------------------
`default_nettype none

package npcd_pkg;

    localparam int BYTE_W         = 8;
    localparam int PAGE_SIZE_W    = 15;
    localparam int SPARE_SIZE_W   = 12;
    localparam int RAW_PAGE_W     = 16;
    localparam int CHUNK_SHIFT    = 9;
    localparam int CWS_W          = PAGE_SIZE_W - CHUNK_SHIFT;
    localparam int CW_POS_W       = 10;
    localparam int THRESH_W       = 11;
    localparam int LIMIT_W        = 17;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;

    localparam int DEFAULT_MAX_PAGE_SIZE = 16384;

    localparam logic [PAGE_SIZE_W-1:0]  RESET_PAGE_SIZE  = PAGE_SIZE_W'(2048);
    localparam logic [SPARE_SIZE_W-1:0] RESET_SPARE_SIZE = SPARE_SIZE_W'(64);

    localparam int CW_SIZE_BCH8      = 532;
    localparam int CW_SIZE_BCH4      = 528;
    localparam int CW_DATA_LAST      = 516;
    localparam int BCH8_SPARE_PER_CW = 20;
    localparam int DATA_CHUNK        = 512;

    localparam logic [CW_POS_W-1:0] CW_LAST_BCH8 = CW_POS_W'(CW_SIZE_BCH8 - 1);
    localparam logic [CW_POS_W-1:0] CW_LAST_BCH4 = CW_POS_W'(CW_SIZE_BCH4 - 1);
    localparam logic [CW_POS_W-1:0] CW_DATA_END  = CW_POS_W'(CW_DATA_LAST);

    // register select, taken from paddr bit 2
    localparam logic REG_PAGE_SIZE  = 1'b0;
    localparam logic REG_SPARE_SIZE = 1'b1;

    typedef logic [CW_POS_W-1:0] bbm_table_t [0:(1 << CWS_W) - 1];

    typedef struct packed {
        logic                   ok;
        logic [CWS_W-1:0]       cws;
        logic [CW_POS_W-1:0]    cw_last;
        logic [CW_POS_W-1:0]    bbm_pos;
        logic [PAGE_SIZE_W-1:0] main_bytes;
        logic [RAW_PAGE_W-1:0]  raw_page;
    } cfg_t;

    // marker offset (n * 512) mod codeword size, built by running remainder
    function automatic bbm_table_t make_bbm_table(input int unsigned cw_size);
        bbm_table_t  tab;
        int unsigned rem;
        int          i;
        rem = 0;
        for (i = 0; i < (1 << CWS_W); i++)
        begin
            tab[i] = CW_POS_W'(rem);
            rem = rem + DATA_CHUNK;
            if (rem >= cw_size)
            begin
                rem = rem - cw_size;
            end
        end
        return tab;
    endfunction

    localparam bbm_table_t BBM_BCH8 = make_bbm_table(CW_SIZE_BCH8);
    localparam bbm_table_t BBM_BCH4 = make_bbm_table(CW_SIZE_BCH4);

endpackage

`default_nettype wire

>>> hdl/npcd_apb_regs.sv
// ----------------------------------------------------------------------------
// npcd_apb_regs
// apb register file for page and spare size, with the derived codeword layout
// ----------------------------------------------------------------------------
`default_nettype none

module npcd_apb_regs #(
    parameter int MAX_PAGE_SIZE = npcd_pkg::DEFAULT_MAX_PAGE_SIZE
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [npcd_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [npcd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [npcd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    output logic                                   cfg_wr,
    output npcd_pkg::cfg_t                         cfg
);

    logic [npcd_pkg::PAGE_SIZE_W-1:0]  main_bytes_reg;
    logic [npcd_pkg::PAGE_SIZE_W-1:0]  main_bytes_next;
    logic [npcd_pkg::SPARE_SIZE_W-1:0] spare_bytes_reg;
    logic [npcd_pkg::SPARE_SIZE_W-1:0] spare_bytes_next;

    logic [npcd_pkg::CWS_W-1:0]    cws;
    logic [npcd_pkg::THRESH_W-1:0] thresh;
    logic                          bch8;
    logic [npcd_pkg::CW_POS_W-1:0] bbm_pos;
    logic                          size_ok;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        main_bytes_next  = main_bytes_reg;
        spare_bytes_next = spare_bytes_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                npcd_pkg::REG_PAGE_SIZE:
                begin
                    main_bytes_next = pwdata[npcd_pkg::PAGE_SIZE_W-1:0];
                end
                npcd_pkg::REG_SPARE_SIZE:
                begin
                    spare_bytes_next = pwdata[npcd_pkg::SPARE_SIZE_W-1:0];
                end
                default:
                begin
                    main_bytes_next = main_bytes_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_bytes_reg  <= npcd_pkg::RESET_PAGE_SIZE;
            spare_bytes_reg <= npcd_pkg::RESET_SPARE_SIZE;
        end
        else
        begin
            main_bytes_reg  <= main_bytes_next;
            spare_bytes_reg <= spare_bytes_next;
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            npcd_pkg::REG_PAGE_SIZE:
            begin
                prdata = npcd_pkg::APB_DATA_W'(main_bytes_reg);
            end
            npcd_pkg::REG_SPARE_SIZE:
            begin
                prdata = npcd_pkg::APB_DATA_W'(spare_bytes_reg);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    // derived codeword layout
    assign cws    = main_bytes_reg[npcd_pkg::PAGE_SIZE_W-1:npcd_pkg::CHUNK_SHIFT];
    assign thresh = npcd_pkg::THRESH_W'(cws) *
                    npcd_pkg::THRESH_W'(npcd_pkg::BCH8_SPARE_PER_CW);
    assign bch8   = {1'b0, spare_bytes_reg} >= {2'b00, thresh};
    assign bbm_pos = bch8 ? npcd_pkg::BBM_BCH8[cws] : npcd_pkg::BBM_BCH4[cws];

    assign size_ok = (main_bytes_reg != '0)
                  && (main_bytes_reg[npcd_pkg::CHUNK_SHIFT-1:0] == '0)
                  && (npcd_pkg::LIMIT_W'(main_bytes_reg)
                      <= npcd_pkg::LIMIT_W'(MAX_PAGE_SIZE));

    assign cfg.ok         = size_ok && (bbm_pos != '0) && (bbm_pos <= npcd_pkg::CW_DATA_END);
    assign cfg.cws        = cws;
    assign cfg.cw_last    = bch8 ? npcd_pkg::CW_LAST_BCH8 : npcd_pkg::CW_LAST_BCH4;
    assign cfg.bbm_pos    = bbm_pos;
    assign cfg.main_bytes = main_bytes_reg;
    assign cfg.raw_page   = npcd_pkg::RAW_PAGE_W'(main_bytes_reg)
                          + npcd_pkg::RAW_PAGE_W'(spare_bytes_reg);

endmodule

`default_nettype wire

>>> hdl/npcd_cw_tracker.sv
// ----------------------------------------------------------------------------
// npcd_cw_tracker
// page and codeword position counters, decides which raw bytes are user data
// ----------------------------------------------------------------------------
`default_nettype none

module npcd_cw_tracker (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step,
    input  wire logic           clear,
    input  wire npcd_pkg::cfg_t cfg,
    output logic                emit,
    output logic                last
);

    logic [npcd_pkg::RAW_PAGE_W-1:0]  page_pos_reg;
    logic [npcd_pkg::RAW_PAGE_W-1:0]  page_pos_next;
    logic [npcd_pkg::CWS_W-1:0]       cw_idx_reg;
    logic [npcd_pkg::CWS_W-1:0]       cw_idx_next;
    logic [npcd_pkg::CW_POS_W-1:0]    cw_pos_reg;
    logic [npcd_pkg::CW_POS_W-1:0]    cw_pos_next;
    logic [npcd_pkg::PAGE_SIZE_W-1:0] coll_reg;
    logic [npcd_pkg::PAGE_SIZE_W-1:0] coll_next;

    logic [npcd_pkg::PAGE_SIZE_W-1:0] coll_inc;
    logic [npcd_pkg::RAW_PAGE_W:0]    page_inc;
    logic                             is_data;

    assign coll_inc = coll_reg + 1'b1;
    assign page_inc = {1'b0, page_pos_reg} + 1'b1;
    assign is_data  = (cw_idx_reg < cfg.cws)
                   && (cw_pos_reg <= npcd_pkg::CW_DATA_END)
                   && (cw_pos_reg != cfg.bbm_pos)
                   && (coll_reg < cfg.main_bytes);

    always_comb
    begin
        page_pos_next = page_pos_reg;
        cw_idx_next   = cw_idx_reg;
        cw_pos_next   = cw_pos_reg;
        coll_next     = coll_reg;
        emit          = 1'b0;
        last          = 1'b0;
        priority if (clear)
        begin
            page_pos_next = '0;
            cw_idx_next   = '0;
            cw_pos_next   = '0;
            coll_next     = '0;
        end
        else if (step && !cfg.ok)
        begin
            page_pos_next = '0;
            cw_idx_next   = '0;
            cw_pos_next   = '0;
            coll_next     = '0;
        end
        else if (step)
        begin
            emit = is_data;
            last = is_data && (coll_inc == cfg.main_bytes);
            if (is_data)
            begin
                coll_next = coll_inc;
            end
            if (cw_pos_reg == cfg.cw_last)
            begin
                cw_pos_next = '0;
                if (cw_idx_reg < cfg.cws)
                begin
                    cw_idx_next = cw_idx_reg + 1'b1;
                end
            end
            else
            begin
                cw_pos_next = cw_pos_reg + 1'b1;
            end
            // end of raw page
            if (page_inc >= {1'b0, cfg.raw_page})
            begin
                page_pos_next = '0;
                cw_idx_next   = '0;
                cw_pos_next   = '0;
                coll_next     = '0;
            end
            else
            begin
                page_pos_next = page_inc[npcd_pkg::RAW_PAGE_W-1:0];
            end
        end
        else
        begin
            // no byte this cycle, hold position
            page_pos_next = page_pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_pos_reg <= '0;
            cw_idx_reg   <= '0;
            cw_pos_reg   <= '0;
            coll_reg     <= '0;
        end
        else
        begin
            page_pos_reg <= page_pos_next;
            cw_idx_reg   <= cw_idx_next;
            cw_pos_reg   <= cw_pos_next;
            coll_reg     <= coll_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/nand_page_codeword_deinterleave_core.sv
// ----------------------------------------------------------------------------
// nand_page_codeword_deinterleave_core
// strips ecc, marker and spare bytes from a raw nand page stream and passes
// on the user data bytes
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------
//  in      | sink      | in_valid/in_stall   | raw_byte
//  out     | source    | out_valid/out_stall | user_byte, page_last
//  cfg     | apb slave | psel/penable        | main size @0, spare size @4
//
//  one raw byte per cycle sustained while the output is not stalled; a byte is
//  registered in the input register and its result then in the output register
//  async reset: main size 2048, spare size 64, all position counters zero
//  an output stall holds one result plus one raw byte, then stalls the input
//  any register write restarts page tracking at the next raw byte
// ----------------------------------------------------------------------------
`default_nettype none

module nand_page_codeword_deinterleave_core #(
    parameter int MAX_PAGE_SIZE = npcd_pkg::DEFAULT_MAX_PAGE_SIZE
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [npcd_pkg::BYTE_W-1:0]       raw_byte,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic      [npcd_pkg::BYTE_W-1:0]       user_byte,
    output logic                                   page_last,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [npcd_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [npcd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [npcd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready
);

    npcd_pkg::cfg_t cfg;
    logic           cfg_wr;

    logic                          a_valid_reg;
    logic                          a_valid_next;
    logic [npcd_pkg::BYTE_W-1:0]   a_byte_reg;
    logic                          o_valid_reg;
    logic                          o_valid_next;
    logic [npcd_pkg::BYTE_W-1:0]   o_byte_reg;
    logic                          o_last_reg;

    logic b_free;
    logic a_move;
    logic in_take;
    logic emit;
    logic last;

    npcd_apb_regs #(
        .MAX_PAGE_SIZE (MAX_PAGE_SIZE)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg_wr  (cfg_wr),
        .cfg     (cfg)
    );

    npcd_cw_tracker u_tracker (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (a_move),
        .clear (cfg_wr),
        .cfg   (cfg),
        .emit  (emit),
        .last  (last)
    );

    assign b_free   = !o_valid_reg || !out_stall;
    assign a_move   = a_valid_reg && b_free;
    assign in_stall = a_valid_reg && !b_free;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (in_take)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_move)
        begin
            a_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        o_valid_next = o_valid_reg;
        if (b_free)
        begin
            o_valid_next = a_move && emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            a_byte_reg <= raw_byte;
        end
        if (a_move && emit)
        begin
            o_byte_reg <= a_byte_reg;
            o_last_reg <= last;
        end
    end

    assign out_valid = o_valid_reg;
    assign user_byte = o_byte_reg;
    assign page_last = o_last_reg;

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the nand page codeword deinterleaver: raw page
// bytes are streamed in under a series of page and spare settings, each
// accepted byte is run through a bit-accurate predictor of the codeword layout,
// and every user byte that comes out is compared in order with the predicted
// byte and page_last flag. both handshakes idle at random, bar the last settings.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int HALF_PERIOD = 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 8;
    localparam logic [npcd_pkg::APB_ADDR_W-1:0] ADDR_PAGE_SIZE  =
        npcd_pkg::APB_ADDR_W'(0);
    localparam logic [npcd_pkg::APB_ADDR_W-1:0] ADDR_SPARE_SIZE =
        npcd_pkg::APB_ADDR_W'(4);

    typedef struct packed {
        logic [npcd_pkg::BYTE_W-1:0] data;
        logic                        last;
    } user_txn_t;

    class user_byte_tracker;
        logic [npcd_pkg::PAGE_SIZE_W-1:0]  main_bytes;
        logic [npcd_pkg::SPARE_SIZE_W-1:0] spare_bytes;
        int unsigned                       page_pos;
        int unsigned                       cw_idx;
        int unsigned                       cw_pos;
        int unsigned                       collected;
        user_txn_t                         expected_user[$];
        int                                errors;

        function void restart_page();
            page_pos  = 0;
            cw_idx    = 0;
            cw_pos    = 0;
            collected = 0;
        endfunction

        function void power_on();
            main_bytes  = npcd_pkg::RESET_PAGE_SIZE;
            spare_bytes = npcd_pkg::RESET_SPARE_SIZE;
            errors      = 0;
            restart_page();
        endfunction

        function void write_reg(logic [npcd_pkg::APB_ADDR_W-1:0] addr,
                                logic [npcd_pkg::APB_DATA_W-1:0] value);
            if (addr == ADDR_PAGE_SIZE)
            begin
                main_bytes = value[npcd_pkg::PAGE_SIZE_W-1:0];
                restart_page();
            end
            else if (addr == ADDR_SPARE_SIZE)
            begin
                spare_bytes = value[npcd_pkg::SPARE_SIZE_W-1:0];
                restart_page();
            end
        endfunction

        function logic [npcd_pkg::APB_DATA_W-1:0] read_reg(
            logic [npcd_pkg::APB_ADDR_W-1:0] addr);
            if (addr == ADDR_PAGE_SIZE)
                return npcd_pkg::APB_DATA_W'(main_bytes);
            return npcd_pkg::APB_DATA_W'(spare_bytes);
        endfunction

        function void take_raw(logic [npcd_pkg::BYTE_W-1:0] raw);
            int unsigned cws;
            int unsigned cw_size;
            int unsigned bbm;
            int unsigned raw_len;
            user_txn_t   txn;
            if (main_bytes == 0 || (main_bytes % npcd_pkg::DATA_CHUNK) != 0 ||
                main_bytes > npcd_pkg::DEFAULT_MAX_PAGE_SIZE)
            begin
                restart_page();
                return;
            end
            cws     = main_bytes / npcd_pkg::DATA_CHUNK;
            cw_size = (spare_bytes >= cws * npcd_pkg::BCH8_SPARE_PER_CW) ?
                      npcd_pkg::CW_SIZE_BCH8 : npcd_pkg::CW_SIZE_BCH4;
            bbm     = main_bytes % cw_size;
            if (bbm == 0 || bbm > npcd_pkg::CW_DATA_LAST)
            begin
                restart_page();
                return;
            end
            raw_len = main_bytes + spare_bytes;
            if (cw_idx < cws && cw_pos <= npcd_pkg::CW_DATA_LAST && cw_pos != bbm &&
                collected < main_bytes)
            begin
                collected++;
                txn.data = raw;
                txn.last = (collected == main_bytes);
                expected_user = {expected_user, txn};
            end
            cw_pos++;
            if (cw_pos >= cw_size)
            begin
                cw_pos = 0;
                if (cw_idx < cws)
                    cw_idx++;
            end
            page_pos++;
            if (page_pos >= raw_len)
                restart_page();
        endfunction

        function void match_user(logic [npcd_pkg::BYTE_W-1:0] data, logic last);
            user_txn_t want;
            if (expected_user.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none, actual byte %02h last %0b",
                         $time, data, last);
                errors++;
                return;
            end
            want = expected_user.pop_front();
            if (want.data !== data)
            begin
                $display("%0t: user_byte mismatch, expected %02h, actual %02h",
                         $time, want.data, data);
                errors++;
            end
            if (want.last !== last)
            begin
                $display("%0t: page_last mismatch, expected %0b, actual %0b",
                         $time, want.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_user.size();
        endfunction
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              in_valid;
    logic                              in_stall;
    logic [npcd_pkg::BYTE_W-1:0]       raw_byte;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic [npcd_pkg::BYTE_W-1:0]       user_byte;
    logic                              page_last;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [npcd_pkg::APB_ADDR_W-1:0]   paddr;
    logic [npcd_pkg::APB_DATA_W-1:0]   pwdata;
    logic [npcd_pkg::APB_DATA_W-1:0]   prdata;
    logic                              pready;

    user_byte_tracker tracker;
    int               send_idle_pct;
    int               recv_idle_pct;
    int               cycles = 0;

    nand_page_codeword_deinterleave_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .raw_byte  (raw_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .user_byte (user_byte),
        .page_last (page_last),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
            out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                tracker.take_raw(raw_byte);
            if (out_valid && !out_stall)
                tracker.match_user(user_byte, page_last);
        end
    end

    task automatic reg_write(input logic [npcd_pkg::APB_ADDR_W-1:0] addr,
                             input logic [npcd_pkg::APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        tracker.write_reg(addr, value);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic reg_readback(input logic [npcd_pkg::APB_ADDR_W-1:0] addr);
        logic [npcd_pkg::APB_DATA_W-1:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        want = tracker.read_reg(addr);
        if (prdata !== want)
        begin
            $display("%0t: prdata mismatch at %0d, expected %0h, actual %0h",
                     $time, addr, want, prdata);
            tracker.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_raw(input logic [npcd_pkg::BYTE_W-1:0] value);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        raw_byte <= value;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_idling(input int mode);
        unique case (mode)
            0:
            begin
                send_idle_pct = 37;
                recv_idle_pct = 48;
            end
            1:
            begin
                send_idle_pct = 48;
                recv_idle_pct = 37;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    task automatic run_setting(input int unsigned pg, input int unsigned sp, input int count);
        reg_write(ADDR_PAGE_SIZE, npcd_pkg::APB_DATA_W'(pg));
        reg_write(ADDR_SPARE_SIZE, npcd_pkg::APB_DATA_W'(sp));
        reg_readback(ADDR_PAGE_SIZE);
        reg_readback(ADDR_SPARE_SIZE);
        repeat (count) send_raw(npcd_pkg::BYTE_W'($urandom));
        drain();
    endtask

    localparam int FIXED_SETTINGS  = 9;
    localparam int RANDOM_SETTINGS = 4;
    localparam int ALL_SETTINGS    = FIXED_SETTINGS + RANDOM_SETTINGS;

    int unsigned fixed_page [FIXED_SETTINGS] = '{512, 512, 0, 1024, 32767, 16384, 16384, 700, 512};
    int unsigned fixed_spare[FIXED_SETTINGS] = '{20, 0, 100, 30, 4095, 4095, 0, 64, 4095};
    int          fixed_count[FIXED_SETTINGS] = '{540, 120, 10, 100, 10, 40, 40, 10, 40};

    logic [npcd_pkg::BYTE_W-1:0] corner_bytes[20] = '{8'h00, 8'hFF, 8'h01, 8'hFE, 8'h55,
                                                     8'hAA, 8'h80, 8'h7F, 8'h0F, 8'hF0,
                                                     8'h00, 8'hFF, 8'h33, 8'hCC, 8'h01,
                                                     8'h80, 8'hFF, 8'h00, 8'h5A, 8'hA5};

    initial
    begin
        int k;
        tracker = new;
        tracker.power_on();
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        raw_byte <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        set_idling(0);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values, then corner bytes on the reset layout
        reg_readback(ADDR_PAGE_SIZE);
        reg_readback(ADDR_SPARE_SIZE);
        for (k = 0; k < 20; k++)
            send_raw(corner_bytes[k]);
        drain();

        for (k = 0; k < ALL_SETTINGS; k++)
        begin
            set_idling(k * 3 / ALL_SETTINGS);
            if (k < FIXED_SETTINGS)
                run_setting(fixed_page[k], fixed_spare[k], fixed_count[k]);
            else
                run_setting(npcd_pkg::DATA_CHUNK * $urandom_range(1, 4),
                            $urandom_range(0, 200), $urandom_range(10, 40));
        end

        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> filelist.f
hdl/npcd_pkg.sv
hdl/npcd_apb_regs.sv
hdl/npcd_cw_tracker.sv
hdl/nand_page_codeword_deinterleave_core.sv
dv/tb_top.sv
